// ===== sv/bbat_pkg.sv =====
// package for the bounding box accumulate/transform block
// types, opcodes, state encoding and reset constants; no dependencies
`default_nettype none
package bbat_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CORNER_COUNT = 8;
    localparam int NUM_REGS = 8;
    localparam int ADDR_W = 6;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_MERGE = 2'd1,
        OP_XFORM = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_NEXT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic simple;      // apply add/merge/clear from input
        logic xf_start;    // reset new bounds, corner/row/axis, fault
        logic mul_step;    // one matrix row of products into accumulators
        logic div_start;   // start divide of current axis
        logic div_done_ack; // fold quotient into bounds, next axis
        logic xf_commit;   // box takes new bounds
        logic out_load;    // result register takes box
    } cmd_t;

    typedef struct packed {
        logic mul_last;
        logic div_busy;
        logic axis_last;
        logic corner_last;
    } stat_t;
endpackage
`default_nettype wire

// ===== sv/bbat_if.sv =====
// valid/ready channel interface carrying a packed payload
// depends on nothing
`default_nettype none
interface bbat_if #(parameter int W = 8) (input wire logic clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/bbat_div.sv =====
// restoring divider: |num| * 2^FRAC / |den|, one quotient bit a cycle
// depends on bbat_pkg
`default_nettype none
module bbat_div #(
    parameter int FRAC_BITS = bbat_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] num,
    input  wire logic signed [63:0] den,
    output logic                    busy,
    output logic signed [31:0]      quo,
    output logic                    fault
);
    localparam int NW = 64 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] n_reg, n_next;
    logic [63:0]   r_reg, r_next;
    logic [63:0]   d_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg, zero_reg, nzero_reg, npos_reg;
    logic [64:0]   trial;
    logic [63:0]   nabs, dabs;
    logic          ovf;
    logic signed [32:0] sq;

    assign nabs = num[63] ? 64'(-num) : 64'(num);
    assign dabs = den[63] ? 64'(-den) : 64'(den);
    assign trial = {r_reg, n_reg[NW-1]};

    always_comb
    begin
        n_next = {n_reg[NW-2:0], 1'b0};
        if (trial >= {1'b0, d_reg})
        begin
            r_next = 64'(trial - {1'b0, d_reg});
            n_next[0] = 1'b1;
        end
        else
        begin
            r_next = trial[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy <= (dabs != 64'd0);
            cnt_reg <= CW'(NW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= {nabs, {FRAC_BITS{1'b0}}};
            r_reg <= '0;
            d_reg <= dabs;
            neg_reg <= num[63] ^ den[63];
            zero_reg <= (dabs == 64'd0);
            nzero_reg <= (num == 64'sd0);
            npos_reg <= !num[63];
        end
        else if (busy)
        begin
            n_reg <= n_next;
            r_reg <= r_next;
        end
    end

    // quotient magnitude must fit the signed 32-bit range
    assign ovf = (n_reg[NW-1:32] != '0)
              || (n_reg[31] && (!neg_reg || n_reg[30:0] != '0));
    assign sq = neg_reg ? -$signed({1'b0, n_reg[31:0]}) : $signed({1'b0, n_reg[31:0]});

    always_comb
    begin
        fault = 1'b0;
        if (zero_reg)
        begin
            fault = 1'b1;
            quo = nzero_reg ? 32'sd0 : (npos_reg ? bbat_pkg::S32_MAX : bbat_pkg::S32_MIN);
        end
        else if (ovf)
        begin
            fault = 1'b1;
            quo = neg_reg ? bbat_pkg::S32_MIN : bbat_pkg::S32_MAX;
        end
        else
        begin
            quo = sq[31:0];
        end
    end
endmodule
`default_nettype wire

// ===== sv/bbat_datapath.sv =====
// box registers, matrix multiply-accumulate, divider and result register
// depends on bbat_pkg, bbat_div
`default_nettype none
module bbat_datapath #(
    parameter int FRAC_BITS = bbat_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bbat_pkg::cmd_t       cmd,
    output bbat_pkg::stat_t           stat,
    input  wire logic [1:0]           opcode,
    input  wire logic signed [31:0]   a_x, a_y, a_z, b_x, b_y, b_z,
    input  wire logic [63:0]          mat [bbat_pkg::NUM_REGS],
    output logic [6*32:0]             result
);
    logic signed [31:0] bmin_reg [3];
    logic signed [31:0] bmax_reg [3];
    logic signed [31:0] bmin_next [3];
    logic signed [31:0] bmax_next [3];
    logic signed [31:0] nmin_reg [3];
    logic signed [31:0] nmax_reg [3];
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [63:0] acc_reg [4];
    logic [2:0] corner_reg;
    logic [1:0] row_reg;     // 0..2 multiply row
    logic [1:0] axis_reg;    // 0..2 divide axis
    logic       fault_reg;
    logic signed [31:0] p, me [4];
    logic signed [63:0] prod [4];
    logic signed [31:0] q;
    logic       qf, dbusy;
    logic signed [63:0] dnum;

    function automatic logic signed [31:0] me3(input int c);
        logic [63:0] r;
        r = mat[6 + c / 2];
        return (c % 2 == 1) ? r[63:32] : r[31:0];
    endfunction

    assign a = '{a_x, a_y, a_z};
    assign b = '{b_x, b_y, b_z};

    always_comb
    begin
        p = corner_reg[row_reg] ? bmax_reg[row_reg] : bmin_reg[row_reg];
        for (int c = 0; c < 4; c++)
        begin
            me[c] = mat[{row_reg, c[1]}][c[0] ? 63 : 31 -: 32];
            prod[c] = (64'(p) * 64'(me[c])) >>> FRAC_BITS;
        end
    end

    always_comb
    begin
        unique case (axis_reg)
            2'd0: dnum = acc_reg[0];
            2'd1: dnum = acc_reg[1];
            default: dnum = acc_reg[2];
        endcase
    end

    bbat_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(dnum),
        .den(acc_reg[3]), .busy(dbusy), .quo(q), .fault(qf)
    );

    assign stat.mul_last = (row_reg == 2'd2);
    assign stat.div_busy = dbusy;
    assign stat.axis_last = (axis_reg == 2'd2);
    assign stat.corner_last = (corner_reg == 3'(bbat_pkg::CORNER_COUNT - 1));

    // box after this transaction, also what the result register shows
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bmin_next[i] = bmin_reg[i];
            bmax_next[i] = bmax_reg[i];
            if (cmd.simple)
            begin
                unique case (bbat_pkg::opcode_t'(opcode))
                    bbat_pkg::OP_CLEAR:
                    begin
                        bmin_next[i] = bbat_pkg::S32_MAX;
                        bmax_next[i] = bbat_pkg::S32_MIN;
                    end
                    bbat_pkg::OP_ADD:
                    begin
                        if (a[i] < bmin_reg[i]) bmin_next[i] = a[i];
                        if (a[i] > bmax_reg[i]) bmax_next[i] = a[i];
                    end
                    bbat_pkg::OP_MERGE:
                    begin
                        if (a[i] < bmin_reg[i]) bmin_next[i] = a[i];
                        if (b[i] > bmax_reg[i]) bmax_next[i] = b[i];
                    end
                    default: ;
                endcase
            end
            else if (cmd.xf_commit)
            begin
                bmin_next[i] = nmin_reg[i];
                bmax_next[i] = nmax_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bmin_reg[i] <= bbat_pkg::S32_MAX;
                bmax_reg[i] <= bbat_pkg::S32_MIN;
            end
        end
        else
        begin
            bmin_reg <= bmin_next;
            bmax_reg <= bmax_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.xf_start)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nmin_reg[i] <= bbat_pkg::S32_MAX;
                nmax_reg[i] <= bbat_pkg::S32_MIN;
            end
            corner_reg <= '0;
            row_reg <= '0;
            axis_reg <= '0;
            fault_reg <= 1'b0;
            for (int c = 0; c < 4; c++)
                acc_reg[c] <= 64'(me3(c));
        end
        else if (cmd.mul_step)
        begin
            for (int c = 0; c < 4; c++)
                acc_reg[c] <= acc_reg[c] + prod[c];
            row_reg <= (row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1;
        end
        else if (cmd.div_done_ack)
        begin
            fault_reg <= fault_reg | qf;
            if (q < nmin_reg[axis_reg]) nmin_reg[axis_reg] <= q;
            if (q > nmax_reg[axis_reg]) nmax_reg[axis_reg] <= q;
            if (axis_reg == 2'd2)
            begin
                axis_reg <= '0;
                corner_reg <= corner_reg + 3'd1;
                for (int c = 0; c < 4; c++)
                    acc_reg[c] <= 64'(me3(c));
            end
            else
            begin
                axis_reg <= axis_reg + 2'd1;
            end
        end
        if (cmd.out_load)
        begin
            result <= {(cmd.xf_commit ? fault_reg : 1'b0),
                       bmax_next[2], bmax_next[1], bmax_next[0],
                       bmin_next[2], bmin_next[1], bmin_next[0]};
        end
    end
endmodule
`default_nettype wire

// ===== sv/bbat_ctrl.sv =====
// controller sequencing simple items and the eight-corner transform
// depends on bbat_pkg
`default_nettype none
module bbat_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [1:0]      opcode,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire bbat_pkg::stat_t stat,
    output bbat_pkg::cmd_t       cmd
);
    bbat_pkg::state_t state_reg, state_next;
    logic ov_reg, ov_next;
    logic take;

    assign in_ready = (state_reg == bbat_pkg::ST_IDLE) && (!ov_reg || out_ready);
    assign take = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bbat_pkg::ST_IDLE:
                if (take && opcode == bbat_pkg::OP_XFORM) state_next = bbat_pkg::ST_MUL;
            bbat_pkg::ST_MUL:
                if (stat.mul_last) state_next = bbat_pkg::ST_DIV;
            bbat_pkg::ST_DIV:
                state_next = bbat_pkg::ST_NEXT;
            bbat_pkg::ST_NEXT:
                if (!stat.div_busy)
                begin
                    if (!stat.axis_last) state_next = bbat_pkg::ST_DIV;
                    else if (!stat.corner_last) state_next = bbat_pkg::ST_MUL;
                    else state_next = bbat_pkg::ST_OUT;
                end
            bbat_pkg::ST_OUT:
                if (!ov_reg || out_ready) state_next = bbat_pkg::ST_IDLE;
            default: state_next = bbat_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        ov_next = ov_reg && !out_ready;
        unique case (state_reg)
            bbat_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if (opcode == bbat_pkg::OP_XFORM) cmd.xf_start = 1'b1;
                    else
                    begin
                        cmd.simple = 1'b1;
                        cmd.out_load = 1'b1;
                        ov_next = 1'b1;
                    end
                end
            end
            bbat_pkg::ST_MUL: cmd.mul_step = 1'b1;
            bbat_pkg::ST_DIV: cmd.div_start = 1'b1;
            bbat_pkg::ST_NEXT: cmd.div_done_ack = !stat.div_busy;
            bbat_pkg::ST_OUT:
                if (!ov_reg || out_ready)
                begin
                    cmd.xf_commit = 1'b1;
                    cmd.out_load = 1'b1;
                    ov_next = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbat_pkg::ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == bbat_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("loaded result not shown");
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.xf_commit |=> state_reg == bbat_pkg::ST_IDLE)
        else $error("commit did not end transform");
endmodule
`default_nettype wire

// ===== sv/bounding_box_accumulate_transform_top.sv =====
// top level: channel interfaces, APB matrix registers, controller and datapath
// depends on bbat_pkg, bbat_if, bbat_ctrl, bbat_datapath
//
//  channel  dir  payload
//  in       sink opcode a_x a_y a_z b_x b_y b_z (194 bits)
//  out      src  min_xyz max_xyz div_fault (193 bits)
//  apb      sink 8 x 64-bit matrix registers at 8*i
//
// add, merge, clear: result valid in the cycle after the transaction, one per cycle;
// a waiting result holds off the next transaction until it leaves
// transform: for each of 8 corners, 3 multiply steps then a divide per axis, then a load;
// the divider makes one quotient bit a cycle, and a zero w does not run it
// reset: empty box, identity matrix; out stalls hold the result register
`default_nettype none
module bounding_box_accumulate_transform_top #(
    parameter int FRAC_BITS = bbat_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bbat_if.sink             in_ch,
    bbat_if.source           out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [bbat_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    logic [63:0] mat_reg [bbat_pkg::NUM_REGS];
    bbat_pkg::cmd_t  cmd;
    bbat_pkg::stat_t stat;
    logic [2:0] ridx;
    localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

    assign pready = 1'b1;
    assign ridx = paddr[5:3];
    assign prdata = mat_reg[ridx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= ONE;
            mat_reg[1] <= '0;
            mat_reg[2] <= ONE << 32;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= ONE;
            mat_reg[6] <= '0;
            mat_reg[7] <= ONE << 32;
        end
        else if (psel && penable && pwrite)
        begin
            mat_reg[ridx] <= pwdata;
        end
    end

    bbat_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid),
        .opcode(in_ch.data[1:0]), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd)
    );

    bbat_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .opcode(in_ch.data[1:0]),
        .a_x(in_ch.data[33:2]), .a_y(in_ch.data[65:34]), .a_z(in_ch.data[97:66]),
        .b_x(in_ch.data[129:98]), .b_y(in_ch.data[161:130]), .b_z(in_ch.data[193:162]),
        .mat(mat_reg), .result(out_ch.data)
    );
endmodule
`default_nettype wire

// ===== tb/bbat_checker.sv =====
// checker for the bounding box accumulate/transform block: mirrors the matrix
// registers, predicts each result box and compares it; depends on bbat_pkg
`default_nettype none
module bbat_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_ready,
    input  wire logic [193:0] in_data,
    input  wire logic         out_valid,
    input  wire logic         out_ready,
    input  wire logic [192:0] out_data,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic         pready,
    input  wire logic [bbat_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]  pwdata,
    output int                mismatches,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = bbat_pkg::FRAC_BITS_DEF;

    // last field sits in the low bits of the transaction
    typedef struct packed {
        logic               div_fault;
        logic signed [31:0] max_z;
        logic signed [31:0] max_y;
        logic signed [31:0] max_x;
        logic signed [31:0] min_z;
        logic signed [31:0] min_y;
        logic signed [31:0] min_x;
    } box_result_t;

    logic [63:0]        matrix [bbat_pkg::NUM_REGS];
    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    box_result_t        expected_boxes [$];

    function automatic longint matrix_entry(int r, int c);
        logic [63:0] w;
        w = matrix[r * 2 + c / 2];
        return (c % 2) ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
    endfunction

    // num * 2^FRAC / den truncated toward zero, clamped to 32 bits
    function automatic logic signed [31:0] scaled_quotient(longint num, longint den,
                                                          inout logic fault);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic         neg;
        longint       s;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? 128'(-num) : 128'(num);
        d = (den < 0) ? 128'(-den) : 128'(den);
        if (d == 0)
        begin
            fault = 1'b1;
            if (num > 0) return bbat_pkg::S32_MAX;
            if (num < 0) return bbat_pkg::S32_MIN;
            return 32'sd0;
        end
        q = n / d;
        if (q >= 128'h1_0000_0000)
        begin
            fault = 1'b1;
            return neg ? bbat_pkg::S32_MIN : bbat_pkg::S32_MAX;
        end
        q = (n << FRAC) / d;
        s = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
        if (s > longint'(bbat_pkg::S32_MAX))
        begin
            fault = 1'b1;
            return bbat_pkg::S32_MAX;
        end
        if (s < longint'(bbat_pkg::S32_MIN))
        begin
            fault = 1'b1;
            return bbat_pkg::S32_MIN;
        end
        return s[31:0];
    endfunction

    function automatic logic transform_box();
        logic signed [31:0] nlo [3];
        logic signed [31:0] nhi [3];
        logic signed [31:0] v;
        longint             p [3];
        longint             acc [4];
        logic               fault;
        fault = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            nlo[c] = bbat_pkg::S32_MAX;
            nhi[c] = bbat_pkg::S32_MIN;
        end
        for (int k = 0; k < bbat_pkg::CORNER_COUNT; k++)
        begin
            for (int a = 0; a < 3; a++)
                p[a] = k[a] ? longint'(box_hi[a]) : longint'(box_lo[a]);
            for (int c = 0; c < 4; c++)
            begin
                acc[c] = matrix_entry(3, c);
                for (int r = 0; r < 3; r++)
                    acc[c] += (p[r] * matrix_entry(r, c)) >>> FRAC;
            end
            for (int c = 0; c < 3; c++)
            begin
                v = scaled_quotient(acc[c], acc[3], fault);
                if (v < nlo[c]) nlo[c] = v;
                if (v > nhi[c]) nhi[c] = v;
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            box_lo[c] = nlo[c];
            box_hi[c] = nhi[c];
        end
        return fault;
    endfunction

    function automatic box_result_t apply_item(logic [193:0] item);
        bbat_pkg::opcode_t  op;
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        logic signed [31:0] hi;
        logic               fault;
        box_result_t        res;
        op = bbat_pkg::opcode_t'(item[1:0]);
        for (int i = 0; i < 3; i++)
        begin
            a[i] = item[2 + 32 * i +: 32];
            b[i] = item[98 + 32 * i +: 32];
        end
        fault = 1'b0;
        case (op)
            bbat_pkg::OP_ADD, bbat_pkg::OP_MERGE:
                for (int i = 0; i < 3; i++)
                begin
                    hi = (op == bbat_pkg::OP_ADD) ? a[i] : b[i];
                    if (a[i] < box_lo[i]) box_lo[i] = a[i];
                    if (hi > box_hi[i]) box_hi[i] = hi;
                end
            bbat_pkg::OP_XFORM: fault = transform_box();
            default:
                for (int i = 0; i < 3; i++)
                begin
                    box_lo[i] = bbat_pkg::S32_MAX;
                    box_hi[i] = bbat_pkg::S32_MIN;
                end
        endcase
        res.min_x = box_lo[0];
        res.min_y = box_lo[1];
        res.min_z = box_lo[2];
        res.max_x = box_hi[0];
        res.max_y = box_hi[1];
        res.max_z = box_hi[2];
        res.div_fault = fault;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        box_result_t want;
        box_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < bbat_pkg::NUM_REGS; i++) matrix[i] = '0;
            matrix[0] = 64'h1 << FRAC;
            matrix[2] = 64'h1 << (FRAC + 32);
            matrix[5] = 64'h1 << FRAC;
            matrix[7] = 64'h1 << (FRAC + 32);
            for (int i = 0; i < 3; i++)
            begin
                box_lo[i] = bbat_pkg::S32_MAX;
                box_hi[i] = bbat_pkg::S32_MIN;
            end
            expected_boxes.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                matrix[paddr[5:3]] = pwdata;
            if (in_valid && in_ready)
                expected_boxes.push_back(apply_item(in_data));
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (expected_boxes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction %p", got);
                end
                else
                begin
                    want = expected_boxes.pop_front();
                    if (got.min_x !== want.min_x || got.min_y !== want.min_y ||
                        got.min_z !== want.min_z || got.max_x !== want.max_x ||
                        got.max_y !== want.max_y || got.max_z !== want.max_z ||
                        got.div_fault !== want.div_fault)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("box mismatch at %0t: expected %p actual %p",
                                     $realtime, want, got);
                    end
                end
            end
            pending = expected_boxes.size();
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_bounding_box_accumulate_transform_top.sv =====
// testbench top: clock, reset, stimulus on the item channel and the APB port,
// verdict; depends on bbat_pkg, bbat_if, bbat_checker and the block
`default_nettype none
module tb_bounding_box_accumulate_transform_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int PHASE_ITEMS = 265;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [bbat_pkg::ADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          mismatches;
    int          pending;
    int          idle_cycles;
    bit          calm;
    bit          hold_req;

    bbat_if #(.W(194)) in_ch (clk);
    bbat_if #(.W(193)) out_ch (clk);

    bounding_box_accumulate_transform_top uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    bbat_checker box_check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .mismatches(mismatches), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic apb_write(int idx, logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= bbat_pkg::ADDR_W'(idx * 8);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_box_op(bbat_pkg::opcode_t op, logic [31:0] ax, logic [31:0] ay,
                               logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                               logic [31:0] bz);
        @(negedge clk);
        in_ch.valid <= 1'b1;
        // opcode in the low bits, then a, then b
        in_ch.data <= {bz, by, bx, az, ay, ax, op};
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
    endtask

    task automatic pause_items(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
    endtask

    task automatic drain_results();
        pause_items(1);
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return bbat_pkg::S32_MAX;
            1: return bbat_pkg::S32_MIN;
            2, 3, 4, 5: return $urandom;
            default: return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
        endcase
    endfunction

    function automatic logic [31:0] small_entry();
        return 32'($urandom_range(0, 4 << 16)) - 32'(2 << 16);
    endfunction

    task automatic load_matrix(int style);
        logic [31:0] e [16];
        for (int i = 0; i < 16; i++)
        begin
            case (style)
                0: e[i] = (i % 5 == 0) ? 32'h1_0000 : 32'h0;
                1: e[i] = (i % 5 == 0) ? small_entry() : ((i >= 12) ? small_entry() : 32'h0);
                2: e[i] = ($urandom_range(0, 5) == 0) ? 32'h0 : small_entry();
                3: e[i] = 32'h0;
                default: e[i] = $urandom_range(0, 1) ? bbat_pkg::S32_MAX : $urandom;
            endcase
        end
        if (style == 1)
        begin
            e[3] = 0;
            e[7] = 0;
            e[11] = 0;
            e[15] = 32'h1_0000;
        end
        for (int r = 0; r < bbat_pkg::NUM_REGS; r++)
            apb_write(r, {e[2 * r + 1], e[2 * r]});
    endtask

    task automatic random_items(int count, bit last_phase);
        bbat_pkg::opcode_t op;
        int          roll;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        for (int n = 0; n < count; n++)
        begin
            if (last_phase && n == count - 150)
                calm = 1'b1;
            roll = $urandom_range(0, 99);
            op = (roll < 52) ? bbat_pkg::OP_ADD : (roll < 85) ? bbat_pkg::OP_MERGE :
                 (roll < 88) ? bbat_pkg::OP_XFORM : bbat_pkg::OP_CLEAR;
            ax = pick_coord();
            ay = pick_coord();
            az = pick_coord();
            if (op == bbat_pkg::OP_MERGE && $urandom_range(0, 3) != 0)
                send_box_op(op, ax, ay, az, ax + 32'($urandom_range(0, 1 << 20)),
                            ay + 32'($urandom_range(0, 1 << 20)),
                            az + 32'($urandom_range(0, 1 << 20)));
            else
                send_box_op(op, ax, ay, az, pick_coord(), pick_coord(), pick_coord());
            if (!calm && $urandom_range(0, 7) == 0)
                pause_items($urandom_range(1, 17));
        end
    endtask

    initial
    begin
        calm = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset identity matrix, directed corners of the fields
        send_box_op(bbat_pkg::OP_XFORM, 0, 0, 0, 0, 0, 0);
        send_box_op(bbat_pkg::OP_ADD, bbat_pkg::S32_MAX, bbat_pkg::S32_MIN, 0, 0, 0, 0);
        send_box_op(bbat_pkg::OP_ADD, bbat_pkg::S32_MIN, bbat_pkg::S32_MAX,
                    32'hFFFF_FFFF, 0, 0, 0);
        send_box_op(bbat_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_box_op(bbat_pkg::OP_MERGE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                    32'h0004_0000, 32'h0005_0000, 32'h0006_0000);
        send_box_op(bbat_pkg::OP_MERGE, 32'h0009_0000, 32'h0009_0000, 32'h0009_0000,
                    32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        send_box_op(bbat_pkg::OP_XFORM, 0, 0, 0, 0, 0, 0);
        send_box_op(bbat_pkg::OP_ADD, bbat_pkg::S32_MAX, bbat_pkg::S32_MAX,
                    bbat_pkg::S32_MAX, 0, 0, 0);
        send_box_op(bbat_pkg::OP_XFORM, 0, 0, 0, 0, 0, 0);
        send_box_op(bbat_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
        send_box_op(bbat_pkg::OP_XFORM, 0, 0, 0, 0, 0, 0);
        send_box_op(bbat_pkg::OP_MERGE, bbat_pkg::S32_MIN, bbat_pkg::S32_MIN,
                    bbat_pkg::S32_MIN, bbat_pkg::S32_MAX, bbat_pkg::S32_MAX,
                    bbat_pkg::S32_MAX);
        send_box_op(bbat_pkg::OP_XFORM, 0, 0, 0, 0, 0, 0);
        send_box_op(bbat_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
        drain_results();

        for (int phase = 0; phase < 6; phase++)
        begin
            load_matrix(phase % 5);
            if (phase == 3)
            begin
                // all-zero matrix: every w is zero
                send_box_op(bbat_pkg::OP_ADD, 32'h0003_0000, 32'hFFFD_0000, 0, 0, 0, 0);
                send_box_op(bbat_pkg::OP_XFORM, 0, 0, 0, 0, 0, 0);
            end
            if (phase == 1)
                hold_req = 1'b1;
            random_items(PHASE_ITEMS, phase == 5);
            if (phase == 2)
                drain_results();
            drain_results();
        end

        pause_items(1);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
